>>> sv/hng_pkg.sv
// ----------------------------------------------------------------------------
// Heightmap normal generator package
// Shared constants, state types and the interface structs of the shared
// normalization unit.
// ----------------------------------------------------------------------------
`default_nettype none
package hng_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = 10;
   localparam int ADDR_W    = 11;
   localparam int ROW_W     = 17;
   localparam int SQ_W      = 34;
   localparam int S_W       = 35;
   localparam int REM_W     = 36;
   localparam int Q_W       = 26;
   localparam int N_W       = 13;
   localparam int DIV_STEPS  = 26;
   localparam int SQRT_STEPS = 13;

   localparam logic [0:0] CSR_GRID_WIDTH = 1'b0;
   localparam logic [0:0] CSR_GRID_ROWS  = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_TRI, S_SQB, S_START, S_WAIT, S_WRITE, S_SUM, S_EMIT
   } hng_state_type;

   typedef enum logic [1:0] {U_IDLE, U_DIV, U_SQRT} hng_ustate_type;

   typedef struct packed {
      logic            start;
      logic [SQ_W-1:0] m_sq;
      logic [S_W-1:0]  s;
   } hng_ureq_type;

   typedef struct packed {
      logic           done;
      logic [N_W-1:0] n;
   } hng_ursp_type;

endpackage
`default_nettype wire

>>> sv/hng_unit.sv
// ----------------------------------------------------------------------------
// Normalization unit
// Computes round(4096 * sqrt(m_sq / s)) by a bit-serial division followed by
// a digit-by-digit square root.
// ----------------------------------------------------------------------------
`default_nettype none
module hng_unit import hng_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire hng_ureq_type ureq,
   output hng_ursp_type      ursp
);

   hng_ustate_type   state_ff, state_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [Q_W-1:0]   quo_ff, quo_in;
   logic [S_W-1:0]   s_ff, s_in;
   logic [Q_W-1:0]   op_ff, op_in;
   logic [Q_W-1:0]   res_ff, res_in;
   logic [Q_W-1:0]   one_ff, one_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [N_W-1:0]   n_ff, n_in;

   logic [REM_W-1:0] sh;
   logic             ge;
   logic [Q_W:0]     t;
   logic             take;

   always_comb begin
      sh   = {rem_ff[REM_W-2:0], 1'b0};
      ge   = sh >= {1'b0, s_ff};
      t    = {1'b0, res_ff} + {1'b0, one_ff};
      take = {1'b0, op_ff} >= t;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         U_IDLE:  if (ureq.start) state_in = U_DIV;
         U_DIV:   if (cnt_ff == 5'(DIV_STEPS - 1)) state_in = U_SQRT;
         U_SQRT:  if (cnt_ff == 5'(SQRT_STEPS - 1)) state_in = U_IDLE;
         default: state_in = U_IDLE;
      endcase
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      s_in    = s_ff;
      op_in   = op_ff;
      res_in  = res_ff;
      one_in  = one_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      n_in    = n_ff;
      case (state_ff)
         U_IDLE: begin
            rem_in = {{(REM_W-SQ_W){1'b0}}, ureq.m_sq};
            quo_in = '0;
            s_in   = ureq.s;
            cnt_in = '0;
         end
         U_DIV: begin
            rem_in = ge ? sh - {1'b0, s_ff} : sh;
            quo_in = {quo_ff[Q_W-2:0], ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_STEPS - 1)) begin
               op_in  = {quo_ff[Q_W-2:0], ge};
               res_in = '0;
               one_in = Q_W'(1) << (Q_W - 2);
               cnt_in = '0;
            end
         end
         U_SQRT: begin
            if (take) begin
               op_in  = op_ff - t[Q_W-1:0];
               res_in = (res_ff >> 1) + one_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            one_in = one_ff >> 2;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(SQRT_STEPS - 1)) begin
               // Round half up: the largest n with 2n-1 <= floor root.
               done_in = 1'b1;
               n_in    = N_W'((res_in + Q_W'(1)) >> 1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      s_ff   <= s_in;
      op_ff  <= op_in;
      res_ff <= res_in;
      one_ff <= one_in;
      n_ff   <= n_in;
   end

   assign ursp.done = done_ff;
   assign ursp.n    = n_ff;

endmodule
`default_nettype wire

>>> sv/heightmap_normal_generator_unit.sv
// An item that builds no rough sum and no normal only reads its neighbors and
// writes back; with four triangles and a normal, each of the twelve components
// holds the shared unit for its start, 26 division and 13 root steps and result.
// Throughput: one item at a time; the next is accepted when the sequencer idles.
// Reset is synchronous and clears counters and control; line buffers are not
// cleared and get no clearing pass.
// ----------------------------------------------------------------------------
// Heightmap normal generator
// Streams heights in raster order and emits smoothed vertex normals two rows
// behind the input, using one shared normalization unit.
// ----------------------------------------------------------------------------
`default_nettype none
module heightmap_normal_generator_unit import hng_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // [15:0] height_sample
   input  wire logic        req_tuser,  // [0] action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [16:0] normal_x, [33:17] normal_y, [50:34] normal_z,
   // [60:51] point_col, [76:61] point_row, [79:77] zero
   output logic [79:0]      rsp_tdata,
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   hng_state_type state_ff, state_in;

   logic [10:0]      grid_width_ff;
   logic [15:0]      grid_rows_ff;
   logic [COL_W-1:0] in_col_ff;
   logic [ROW_W-1:0] in_row_ff;

   logic [15:0] hmem [0:2*MAX_WIDTH-1];
   logic [47:0] rmem [0:2*MAX_WIDTH-1];
   logic [15:0] h_rd_ff;
   logic [47:0] r_rd_ff;

   logic signed [15:0] hnew_ff;
   logic [15:0]        hv_ff [0:3];
   logic [47:0]        rv_ff [0:3];
   logic [2:0]         rd_cnt_ff;
   logic [1:0]         tri_ff;
   logic [1:0]         comp_ff;
   logic [SQ_W-1:0]    sqa_ff, sqb_ff;
   logic signed [15:0] acc_ff [0:2];
   logic signed [16:0] sum_ff [0:2];
   logic               rsp_valid_ff;
   logic [79:0]        rsp_data_ff;
   logic               rsp_last_ff;

   hng_ureq_type ureq;
   hng_ursp_type ursp;

   logic [10:0]      w_eff;
   logic [ROW_W-1:0] r_eff;
   logic             samp, have_rough, emit, has_l, has_r, nb_d;
   logic             cur, prv;
   logic [COL_W-1:0] c_m1, c_p1;
   logic [3:0]       tri_en;
   logic             accept, out_free, h_we, r_we, advance;
   logic [ADDR_W-1:0] h_raddr, r_raddr;
   logic signed [17:0] hc, dd, du, dl, dr, ta, tb;
   logic [16:0]        a_mag, b_mag, mul_op;
   logic [SQ_W-1:0]    prod;
   logic               neg;
   logic signed [15:0] term;
   logic signed [18:0] nb [0:2];
   logic signed [16:0] sum_c [0:2];
   logic [1:0]         rd_idx;
   logic               zero;

   always_comb begin
      if (grid_width_ff == 11'd0) w_eff = 11'd1;
      else if (grid_width_ff > 11'(MAX_WIDTH)) w_eff = 11'(MAX_WIDTH);
      else w_eff = grid_width_ff;
      r_eff      = (grid_rows_ff == 16'd0) ? ROW_W'(1) : {1'b0, grid_rows_ff};
      samp       = in_row_ff < r_eff;
      have_rough = (in_row_ff != '0) && (in_row_ff <= r_eff);
      emit       = in_row_ff >= ROW_W'(2);
      nb_d       = in_row_ff >= ROW_W'(3);
      has_l      = in_col_ff != '0;
      has_r      = ({1'b0, in_col_ff} + 11'd1) < w_eff;
      cur        = in_row_ff[0];
      prv        = ~in_row_ff[0];
      c_m1       = in_col_ff - COL_W'(1);
      c_p1       = in_col_ff + COL_W'(1);
      // Triangles: left/down, left/up, up/right, right/down.
      tri_en     = {has_r & emit, has_r & samp, has_l & samp, has_l & emit};
      accept     = req_tvalid && req_tready;
      out_free   = !rsp_valid_ff || rsp_tready;
      rd_idx     = 2'(rd_cnt_ff - 3'd1);
   end

   always_comb begin
      case (rd_cnt_ff[1:0])
         2'd0:    begin h_raddr = {cur, in_col_ff}; r_raddr = {cur, in_col_ff}; end
         2'd1:    begin h_raddr = {prv, in_col_ff}; r_raddr = {cur, c_m1};      end
         2'd2:    begin h_raddr = {prv, c_m1};      r_raddr = {cur, c_p1};      end
         default: begin h_raddr = {prv, c_p1};      r_raddr = {prv, in_col_ff}; end
      endcase
   end

   always_comb begin
      hc = 18'(signed'(hv_ff[1]));
      dd = 18'(signed'(hv_ff[0])) - hc;
      du = 18'(hnew_ff) - hc;
      dl = 18'(signed'(hv_ff[2])) - hc;
      dr = 18'(signed'(hv_ff[3])) - hc;
      case (tri_ff)
         2'd0:    begin ta = dl;  tb = dd;  end
         2'd1:    begin ta = dl;  tb = -du; end
         2'd2:    begin ta = -dr; tb = -du; end
         default: begin ta = -dr; tb = dd;  end
      endcase
      a_mag  = ta[17] ? 17'(-ta) : ta[16:0];
      b_mag  = tb[17] ? 17'(-tb) : tb[16:0];
      mul_op = (state_ff == S_TRI) ? a_mag : b_mag;
      prod   = mul_op * mul_op;
   end

   always_comb begin
      ureq.s = {1'b0, sqa_ff} + {1'b0, sqb_ff} + S_W'(65536);
      case (comp_ff)
         2'd0:    begin ureq.m_sq = sqa_ff;          neg = ta[17]; end
         2'd1:    begin ureq.m_sq = SQ_W'(65536);    neg = 1'b0;   end
         default: begin ureq.m_sq = sqb_ff;          neg = tb[17]; end
      endcase
      term = neg ? -16'(ursp.n) : 16'(ursp.n);
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         nb[k] = (has_l ? 19'(signed'(rv_ff[1][16*k +: 16])) : 19'sd0)
               + (has_r ? 19'(signed'(rv_ff[2][16*k +: 16])) : 19'sd0)
               + (nb_d ? 19'(signed'(rv_ff[3][16*k +: 16])) : 19'sd0)
               + (have_rough ? 19'(acc_ff[k]) : 19'sd0);
         sum_c[k] = 17'(signed'(rv_ff[0][16*k +: 16])) + 17'(nb[k] >>> 1);
      end
      zero = (sum_ff[0] == '0) && (sum_ff[1] == '0) && (sum_ff[2] == '0);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept && !(samp && req_tuser)) state_in = S_READ;
         S_READ:  if (rd_cnt_ff == 3'd4) state_in = have_rough ? S_TRI : S_WRITE;
         S_TRI: begin
            if (tri_en[tri_ff]) state_in = S_SQB;
            else if (tri_ff == 2'd3) state_in = S_WRITE;
         end
         S_SQB:   state_in = S_START;
         S_START: state_in = S_WAIT;
         S_WAIT: begin
            if (ursp.done) begin
               if (comp_ff != 2'd2) state_in = S_START;
               else state_in = (tri_ff == 2'd3) ? S_WRITE : S_TRI;
            end
         end
         S_WRITE: state_in = emit ? S_SUM : S_IDLE;
         S_SUM:   state_in = S_EMIT;
         S_EMIT:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_tready = state_ff == S_IDLE;
      h_we       = (state_ff == S_WRITE) && samp;
      r_we       = (state_ff == S_WRITE) && have_rough;
      ureq.start = state_ff == S_START;
      advance    = ((state_ff == S_WRITE) && !emit) || ((state_ff == S_EMIT) && out_free);
      csr_ready  = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (h_we) hmem[{cur, in_col_ff}] <= hnew_ff;
      h_rd_ff <= hmem[h_raddr];
   end

   always_ff @(posedge clock) begin
      if (r_we) rmem[{prv, in_col_ff}] <= {acc_ff[2], acc_ff[1], acc_ff[0]};
      r_rd_ff <= rmem[r_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         grid_width_ff <= 11'd1024;
         grid_rows_ff  <= 16'd1024;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_cnt_ff     <= '0;
         tri_ff        <= '0;
         comp_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_EMIT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         if (accept) begin
            rd_cnt_ff <= '0;
            tri_ff    <= '0;
            comp_ff   <= '0;
         end
         if (state_ff == S_READ) rd_cnt_ff <= rd_cnt_ff + 3'd1;
         if (state_ff == S_TRI && !tri_en[tri_ff]) tri_ff <= tri_ff + 2'd1;
         if (state_ff == S_WAIT && ursp.done) begin
            if (comp_ff == 2'd2) begin
               comp_ff <= '0;
               tri_ff  <= tri_ff + 2'd1;
            end else begin
               comp_ff <= comp_ff + 2'd1;
            end
         end
         // A register write restarts the frame.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GRID_WIDTH: grid_width_ff <= csr_data[10:0];
               CSR_GRID_ROWS:  grid_rows_ff  <= csr_data;
               default: ;
            endcase
            in_col_ff <= '0;
            in_row_ff <= '0;
         end else if (advance) begin
            if (({1'b0, in_col_ff} + 11'd1) >= w_eff) begin
               in_col_ff <= '0;
               if ((in_row_ff + ROW_W'(1)) >= (r_eff + ROW_W'(2))) in_row_ff <= '0;
               else in_row_ff <= in_row_ff + ROW_W'(1);
            end else begin
               in_col_ff <= c_p1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hnew_ff <= signed'(req_tdata);
         for (int k = 0; k < 3; k++) acc_ff[k] <= '0;
      end
      if (state_ff == S_READ && rd_cnt_ff != 3'd0) begin
         hv_ff[rd_idx] <= h_rd_ff;
         rv_ff[rd_idx] <= r_rd_ff;
      end
      if (state_ff == S_TRI) sqa_ff <= prod;
      if (state_ff == S_SQB) sqb_ff <= prod;
      if (state_ff == S_WAIT && ursp.done) acc_ff[comp_ff] <= acc_ff[comp_ff] + term;
      if (state_ff == S_SUM) begin
         for (int k = 0; k < 3; k++) sum_ff[k] <= sum_c[k];
      end
      if (state_ff == S_EMIT && out_free) begin
         rsp_data_ff <= {3'b000, 16'(in_row_ff - ROW_W'(2)), in_col_ff,
                         sum_ff[2], zero ? 17'sd4096 : sum_ff[1], sum_ff[0]};
         rsp_last_ff <= (({1'b0, in_col_ff} + 11'd1) == w_eff)
                     && ((in_row_ff - ROW_W'(1)) == r_eff);
      end
   end

   hng_unit u_unit (
      .clock (clock),
      .reset (reset),
      .ureq  (ureq),
      .ursp  (ursp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      ursp.done |-> state_ff == S_WAIT)
      else $error("normalization result arrived outside the wait state");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, in_col_ff} < w_eff) || $past(csr_valid))
      else $error("column counter beyond the row width");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && out_free) |=> rsp_tvalid)
      else $error("emitted normal not presented on the output");

   a_tri_only_rough: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_START) |-> (have_rough && tri_en[tri_ff]))
      else $error("triangle started for a disabled neighbor set");

endmodule
`default_nettype wire

>>> test/heightmap_normal_generator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heightmap normal generator testbench
// Streams height frames of many sizes into the block and checks every
// smoothed normal against a local predictor, under varied valid/ready idling,
// a long output hold-off and grid register changes between frames.
// ----------------------------------------------------------------------------
module heightmap_normal_generator_unit_tb import hng_pkg::*; ();

   localparam int RANDOM_ITEMS   = 950;
   localparam int SETTLE_CYCLES  = 600;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 4000;
   localparam bit ACT_SAMPLE     = 1'b0;
   localparam bit ACT_FLUSH      = 1'b1;

   typedef struct {
      logic [16:0] nx, ny, nz;
      logic [9:0]  col;
      logic [15:0] row;
      bit          last;
   } normal_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = CSR_GRID_WIDTH;
   logic [15:0] csr_data = '0;

   heightmap_normal_generator_unit dut (.*);

   always #2 clock = ~clock;

   // Predictor state.
   bit signed [15:0] height_line[2*MAX_WIDTH];
   bit signed [15:0] rough_x[2*MAX_WIDTH], rough_y[2*MAX_WIDTH], rough_z[2*MAX_WIDTH];
   int unsigned grid_width = 1024, grid_rows = 1024;
   int unsigned in_col = 0, in_row = 0;
   normal_type  pending_normals[$];

   int  error_count = 0;
   int  items_sent = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_request = 1'b0;
   int  quiet_cycles = 0;
   int  last_height = 0;

   function automatic int unsigned unit_mag(longint unsigned m, longint unsigned s);
      longint unsigned t, k;
      int unsigned lo, hi, mid;
      t = (m * m) << 26;
      lo = 0;
      hi = 4096;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         k = 64'(2 * mid - 1);
         if (k * k * s <= t) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic int unit_comp(int a, longint unsigned s);
      int n;
      n = int'(unit_mag(64'(a < 0 ? -a : a), s));
      return a < 0 ? -n : n;
   endfunction

   task automatic add_triangle(inout int ax, inout int ay, inout int az, input int a, b);
      longint unsigned s;
      s = 64'(longint'(a) * a) + 64'(longint'(b) * b) + 64'd65536;
      ax += unit_comp(a, s);
      ay += unit_comp(256, s);
      az += unit_comp(b, s);
   endtask

   task automatic predict_item(input bit act, input logic [15:0] h);
      int unsigned wd, rw, c, r, cur, prv, z;
      bit samp, have_rough, emit, has_d, has_u, has_l, has_r;
      int hnew, hdown2, hc, dd, du, dl, dr;
      int rx, ry, rz, ox, oy, oz, nbx, nby, nbz;
      bit signed [15:0] oldx, oldy, oldz;
      normal_type e;
      wd = grid_width == 0 ? 1 : (grid_width > MAX_WIDTH ? MAX_WIDTH : grid_width);
      rw = grid_rows == 0 ? 1 : grid_rows;
      c = in_col;
      r = in_row;
      samp = r < rw;
      if (samp && act == ACT_FLUSH) return;
      cur = (r & 1) * MAX_WIDTH;
      prv = ((r + 1) & 1) * MAX_WIDTH;
      have_rough = r >= 1 && r <= rw;
      emit = r >= 2 && r - 2 < rw;
      hnew = int'($signed(h));
      hdown2 = height_line[cur + c];
      rx = 0; ry = 0; rz = 0;
      if (have_rough) begin
         hc = height_line[prv + c];
         has_d = r - 1 > 0;
         has_u = r < rw;
         has_l = c > 0;
         has_r = c + 1 < wd;
         dd = has_d ? hdown2 - hc : 0;
         du = has_u ? hnew - hc : 0;
         dl = has_l ? height_line[prv + c - 1] - hc : 0;
         dr = has_r ? height_line[prv + c + 1] - hc : 0;
         if (has_l && has_d) add_triangle(rx, ry, rz, dl, dd);
         if (has_l && has_u) add_triangle(rx, ry, rz, dl, -du);
         if (has_r && has_u) add_triangle(rx, ry, rz, -dr, -du);
         if (has_r && has_d) add_triangle(rx, ry, rz, -dr, dd);
      end
      oldx = rough_x[prv + c];
      oldy = rough_y[prv + c];
      oldz = rough_z[prv + c];
      if (samp) height_line[cur + c] = h;
      if (have_rough) begin
         rough_x[prv + c] = rx[15:0];
         rough_y[prv + c] = ry[15:0];
         rough_z[prv + c] = rz[15:0];
      end
      if (emit) begin
         z = r - 2;
         ox = rough_x[cur + c];
         oy = rough_y[cur + c];
         oz = rough_z[cur + c];
         nbx = 0; nby = 0; nbz = 0;
         if (c > 0) begin
            nbx += rough_x[cur + c - 1]; nby += rough_y[cur + c - 1]; nbz += rough_z[cur + c - 1];
         end
         if (c + 1 < wd) begin
            nbx += rough_x[cur + c + 1]; nby += rough_y[cur + c + 1]; nbz += rough_z[cur + c + 1];
         end
         if (z > 0) begin
            nbx += oldx; nby += oldy; nbz += oldz;
         end
         if (z + 1 < rw) begin
            nbx += rx; nby += ry; nbz += rz;
         end
         ox += nbx >>> 1;
         oy += nby >>> 1;
         oz += nbz >>> 1;
         if (ox == 0 && oy == 0 && oz == 0) oy = 4096;
         e.nx = ox[16:0];
         e.ny = oy[16:0];
         e.nz = oz[16:0];
         e.col = c[9:0];
         e.row = z[15:0];
         e.last = (c + 1 == wd) && (z + 1 == rw);
         pending_normals.push_back(e);
      end
      c++;
      if (c >= wd) begin
         c = 0;
         r++;
         if (r >= rw + 2) r = 0;
      end
      in_col = c;
      in_row = r;
   endtask

   task automatic send_item(input bit act, input logic [15:0] h);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = act;
      req_tdata = h;
      do @(posedge clock); while (!req_tready);
      predict_item(act, h);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_register(input logic [0:0] idx, input logic [15:0] value);
      req_tvalid = 1'b0;
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_GRID_WIDTH) grid_width = value[10:0];
      else grid_rows = value;
      in_col = 0;
      in_row = 0;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Waits until every expected normal has come out and the sequencer has
   // had time to finish an item that produces none.
   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (pending_normals.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_height();
      int h;
      case ($urandom_range(4))
         0: h = int'($signed(16'($urandom())));
         1: h = $urandom_range(1) ? 32767 : -32768;
         default: h = last_height + int'($urandom_range(512)) - 256;
      endcase
      if (h > 32767) h = 32767;
      if (h < -32768) h = -32768;
      last_height = h;
      return 16'(h);
   endfunction

   // Sends one frame; with noise, stray flushes and late samples are mixed in.
   // A positive cut stops the frame after that many transactions.
   task automatic run_frame(input bit noisy, input int cut);
      int n;
      bit act;
      n = 0;
      do begin
         if (in_row < (grid_rows == 0 ? 1 : grid_rows))
            act = (noisy && $urandom_range(99) < 4) ? ACT_FLUSH : ACT_SAMPLE;
         else
            act = (noisy && $urandom_range(99) < 15) ? ACT_SAMPLE : ACT_FLUSH;
         send_item(act, pick_height());
         n++;
      end while (!(in_row == 0 && in_col == 0) && !(cut > 0 && n >= cut));
   endtask

   task automatic set_grid(input int wd, input int rw);
      wait_idle();
      write_register(CSR_GRID_WIDTH, 16'(wd));
      write_register(CSR_GRID_ROWS, 16'(rw));
   endtask

   task automatic test_extreme_heights();
      set_grid(3, 3);
      send_item(ACT_SAMPLE, 16'h7FFF);
      send_item(ACT_FLUSH, 16'h1234);
      send_item(ACT_SAMPLE, 16'h8000);
      send_item(ACT_SAMPLE, 16'h7FFF);
      send_item(ACT_SAMPLE, 16'h0000);
      send_item(ACT_SAMPLE, 16'h8000);
      send_item(ACT_SAMPLE, 16'hFFFF);
      send_item(ACT_SAMPLE, 16'h7FFF);
      send_item(ACT_SAMPLE, 16'h8000);
      send_item(ACT_SAMPLE, 16'h0001);
      // Samples after the last row count as flushes.
      send_item(ACT_SAMPLE, 16'h5A5A);
      while (!(in_row == 0 && in_col == 0)) send_item(ACT_FLUSH, 16'hA5A5);
   endtask

   task automatic test_degenerate_grids();
      set_grid(0, 2);
      run_frame(1'b0, 0);
      set_grid(4, 0);
      run_frame(1'b0, 0);
      // Widest and tallest grid settings; the frame is abandoned early.
      set_grid(2047, 65535);
      repeat (3) send_item(ACT_SAMPLE, pick_height());
   endtask

   task automatic test_random_frames();
      int frame;
      frame = 0;
      while (items_sent < RANDOM_ITEMS) begin
         case (frame % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         if ($urandom_range(9) == 0) set_grid($urandom_range(1, 40), $urandom_range(1, 3));
         else set_grid($urandom_range(1, 10), $urandom_range(1, 7));
         if ($urandom_range(9) == 0) run_frame(1'b1, $urandom_range(1, 20));
         else run_frame($urandom_range(2) == 0, 0);
         frame++;
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   task automatic test_output_backpressure();
      set_grid(5, 3);
      hold_request = 1'b1;
      run_frame(1'b0, 0);
   endtask

   always @(negedge clock) begin
      if (hold_request) begin
         rsp_tready = 1'b0;
         repeat (HOLD_CYCLES) @(negedge clock);
         hold_request = 1'b0;
      end
      rsp_tready = $urandom_range(99) >= recv_stall_pct;
   end

   always @(posedge clock) begin
      normal_type e;
      logic [16:0] ax, ay, az;
      if (!reset && rsp_tvalid && rsp_tready) begin
         ax = rsp_tdata[16:0];
         ay = rsp_tdata[33:17];
         az = rsp_tdata[50:34];
         if (pending_normals.size() == 0) begin
            $error("unexpected normal transaction: col %0d row %0d",
                   rsp_tdata[60:51], rsp_tdata[76:61]);
            error_count++;
         end else begin
            e = pending_normals.pop_front();
            if (ax !== e.nx) begin
               $error("normal_x: expected %0d, got %0d", $signed(e.nx), $signed(ax));
               error_count++;
            end
            if (ay !== e.ny) begin
               $error("normal_y: expected %0d, got %0d", $signed(e.ny), $signed(ay));
               error_count++;
            end
            if (az !== e.nz) begin
               $error("normal_z: expected %0d, got %0d", $signed(e.nz), $signed(az));
               error_count++;
            end
            if (rsp_tdata[60:51] !== e.col) begin
               $error("point_col: expected %0d, got %0d", e.col, rsp_tdata[60:51]);
               error_count++;
            end
            if (rsp_tdata[76:61] !== e.row) begin
               $error("point_row: expected %0d, got %0d", e.row, rsp_tdata[76:61]);
               error_count++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last: expected %0d, got %0d", e.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_extreme_heights();
      test_degenerate_grids();
      test_output_backpressure();
      test_random_frames();
      wait_idle();
      if (error_count == 0 && pending_normals.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
